@@ rtl/tpo_pkg.sv @@
package tpo_pkg;

  // Input coordinates are signed Q8.16.
  localparam int CoordW   = 24;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int CrossW   = ProdW + 1;
  // Cross product magnitudes never exceed 2^49.
  localparam int MagW     = 50;
  localparam int ShiftW   = 6;
  localparam int HalfW    = MagW / 2;
  localparam int SumW     = 2 * MagW;
  localparam int RootW    = 51;
  localparam int FracW    = 30;
  localparam int QuotW    = FracW + 1;
  localparam int NormW    = 32;
  localparam int OfsW     = 26;
  localparam int LenW     = 36;
  localparam int LenShift = 16;
  localparam int DotW     = NormW + CoordW + 2;

  // Index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][CoordW-1:0] vec_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    logic [2:0][MagW-1:0] cs;
    logic [2:0]           neg;
    logic [ShiftW-1:0]    k;
    logic                 deg;
    vec_t                 v1;
    vec_t                 pt;
  } geo_t;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic [RootW-1:0] lp;
    geo_t             geo;
  } div_side_t;

  typedef struct packed {
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
    logic signed [OfsW-1:0]  offset;
    logic [LenW-1:0]         len;
    logic                    deg;
    logic                    flip;
  } result_t;

endpackage

@@ rtl/triangle_plane_orient_top.sv @@
// Oriented plane of a triangle, fully pipelined.
// Input words on in_t*: three vertices and an interior point, signed Q8.16.
// Result words on out_t*: unit normal (Q2.30), plane offset (Q10.16),
// cross product length (Q20.16) and the degenerate and flipped flags.
// cfg_we writes the half-space tolerance (signed Q8.16); write it only
// while no word is in flight.
// From input acceptance to out_tvalid a word passes the cross product and
// its normalized squared length, the bit-per-stage square root, the three
// parallel bit-per-stage dividers, the dot products, orientation test and
// saturation, and the output register.
// One word is accepted every cycle while the output keeps up.
// A one-word skid register sits behind the output register; when the
// receiver stalls, the skid fills and then the whole pipeline holds,
// in_tready drops, and nothing is lost or repeated.
// Reset clears all valid bits, empties the output and sets the tolerance
// to zero.
module triangle_plane_orient_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z, inner_x, inner_y, inner_z (24 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // normal_x[31:0], normal_y[63:32], normal_z[95:64], plane_offset[121:96],
  // cross_length[157:122], two zero bits
  output logic [159:0] out_tdata,
  // degenerate[0], was_flipped[1]
  output logic [1:0]   out_tuser
);

  localparam int CoordW = tpo_pkg::CoordW;

  logic [CoordW-1:0] tol_r;
  logic              adv;
  tpo_pkg::vec_t     v1, v2, v3, pt;

  logic                              cr_valid;
  logic [tpo_pkg::SumW-1:0]          cr_sum;
  tpo_pkg::geo_t                     cr_geo;
  logic                              sq_valid;
  logic [tpo_pkg::RootW-1:0]         sq_root;
  tpo_pkg::geo_t                     sq_geo;
  logic                              dv_valid;
  logic [2:0][tpo_pkg::QuotW-1:0]    dv_quot;
  tpo_pkg::div_side_t                dv_side;
  logic                              pl_valid;
  tpo_pkg::result_t                  pl_res;

  logic              out_valid_r;
  logic              skid_valid_r;
  tpo_pkg::result_t  out_res_r;
  tpo_pkg::result_t  skid_res_r;
  logic              push;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v1[i] = in_tdata[i * CoordW +: CoordW];
      v2[i] = in_tdata[(3 + i) * CoordW +: CoordW];
      v3[i] = in_tdata[(6 + i) * CoordW +: CoordW];
      pt[i] = in_tdata[(9 + i) * CoordW +: CoordW];
    end
  end

  // The pipeline moves whenever the skid register is free.
  assign adv       = !skid_valid_r;
  assign in_tready = adv;
  assign push      = adv && pl_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  tpo_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_v1     (v1),
    .in_v2     (v2),
    .in_v3     (v3),
    .in_pt     (pt),
    .out_valid (cr_valid),
    .out_sum   (cr_sum),
    .out_geo   (cr_geo)
  );

  tpo_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cr_valid),
    .in_sum    (cr_sum),
    .in_geo    (cr_geo),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_geo   (sq_geo)
  );

  tpo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_geo    (sq_geo),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  tpo_plane u_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv_valid),
    .in_quot   (dv_quot),
    .in_side   (dv_side),
    .tol       (tol_r),
    .out_valid (pl_valid),
    .out_res   (pl_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_res_r <= skid_valid_r ? skid_res_r : pl_res;
    end else if (push) begin
      skid_res_r <= pl_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.len, out_res_r.offset,
                       out_res_r.nz, out_res_r.ny, out_res_r.nx};
  assign out_tuser  = {out_res_r.flip, out_res_r.deg};

endmodule

@@ rtl/tpo_cross.sv @@
module tpo_cross (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  tpo_pkg::vec_t              in_v1,
  input  tpo_pkg::vec_t              in_v2,
  input  tpo_pkg::vec_t              in_v3,
  input  tpo_pkg::vec_t              in_pt,
  output logic                       out_valid,
  output logic [tpo_pkg::SumW-1:0]   out_sum,
  output tpo_pkg::geo_t              out_geo
);

  localparam int NSt    = 10;
  localparam int DiffW  = tpo_pkg::DiffW;
  localparam int ProdW  = tpo_pkg::ProdW;
  localparam int CrossW = tpo_pkg::CrossW;
  localparam int MagW   = tpo_pkg::MagW;
  localparam int HalfW  = tpo_pkg::HalfW;
  localparam int SumW   = tpo_pkg::SumW;
  localparam int ShiftW = tpo_pkg::ShiftW;

  logic [NSt-1:0] vld_r;

  logic signed [DiffW-1:0]  p1_r [3];
  logic signed [DiffW-1:0]  q1_r [3];
  logic signed [ProdW-1:0]  a2_r [3];
  logic signed [ProdW-1:0]  b2_r [3];
  logic signed [CrossW-1:0] c3_r [3];
  logic [MagW-1:0]          m4_r [3];
  logic [MagW-1:0]          m5_r [3];
  logic [MagW-1:0]          m6_r [3];
  logic [MagW-1:0]          top5_r;
  logic [ShiftW-1:0]        k_r [6:NSt];
  logic                     deg_r [6:NSt];
  logic [2:0]               neg_r [4:NSt];
  logic [2:0][MagW-1:0]     cs_r [7:NSt];
  logic [ProdW-1:0]         hh8_r [3];
  logic [ProdW-1:0]         hl8_r [3];
  logic [ProdW-1:0]         ll8_r [3];
  logic [SumW-1:0]          sq9_r [3];
  logic [SumW-1:0]          sum10_r;
  tpo_pkg::vec_t            v1_r [1:NSt];
  tpo_pkg::vec_t            pt_r [1:NSt];
  logic [MagW-1:0]          top_c;

  // Largest k for which top << k stays at or below 2^(MagW-1).
  function automatic logic [ShiftW-1:0] norm_shift(input logic [MagW-1:0] top);
    logic [MagW-1:0]   d;
    logic [ShiftW-1:0] k;
    d = top - MagW'(1);
    k = ShiftW'(MagW - 1);
    for (int i = 0; i < MagW; i++) begin
      if (d[i]) k = ShiftW'(MagW - 2 - i);
    end
    return k;
  endfunction

  always_comb begin
    top_c = (m4_r[0] > m4_r[1]) ? m4_r[0] : m4_r[1];
    if (m4_r[2] > top_c) top_c = m4_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSt-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= DiffW'($signed(in_v3[i])) - DiffW'($signed(in_v2[i] ^ in_v2[i] ^ in_v1[i]));
        q1_r[i] <= DiffW'($signed(in_v2[i])) - DiffW'($signed(in_v1[i]));
      end
      a2_r[0] <= p1_r[1] * q1_r[2];
      b2_r[0] <= p1_r[2] * q1_r[1];
      a2_r[1] <= p1_r[2] * q1_r[0];
      b2_r[1] <= p1_r[0] * q1_r[2];
      a2_r[2] <= p1_r[0] * q1_r[1];
      b2_r[2] <= p1_r[1] * q1_r[0];
      for (int i = 0; i < 3; i++) begin
        c3_r[i]     <= CrossW'(a2_r[i]) - CrossW'(b2_r[i]);
        neg_r[4][i] <= c3_r[i][CrossW-1];
        m4_r[i]     <= MagW'(c3_r[i][CrossW-1] ? -c3_r[i] : c3_r[i]);
        m5_r[i]     <= m4_r[i];
        m6_r[i]     <= m5_r[i];
        cs_r[7][i]  <= MagW'(m6_r[i] << k_r[6]);
        hh8_r[i]    <= cs_r[7][i][MagW-1:HalfW] * cs_r[7][i][MagW-1:HalfW];
        hl8_r[i]    <= cs_r[7][i][MagW-1:HalfW] * cs_r[7][i][HalfW-1:0];
        ll8_r[i]    <= cs_r[7][i][HalfW-1:0] * cs_r[7][i][HalfW-1:0];
        sq9_r[i]    <= (SumW'(hh8_r[i]) << (2 * HalfW)) + (SumW'(hl8_r[i]) << (HalfW + 1))
                       + SumW'(ll8_r[i]);
      end
      top5_r   <= top_c;
      k_r[6]   <= norm_shift(top5_r);
      deg_r[6] <= (top5_r == '0);
      sum10_r  <= sq9_r[0] + sq9_r[1] + sq9_r[2];
      v1_r[1]  <= in_v1;
      pt_r[1]  <= in_pt;
      for (int s = 2; s <= NSt; s++) begin
        v1_r[s] <= v1_r[s-1];
        pt_r[s] <= pt_r[s-1];
      end
      for (int s = 5; s <= NSt; s++) neg_r[s] <= neg_r[s-1];
      for (int s = 7; s <= NSt; s++) begin
        k_r[s]   <= k_r[s-1];
        deg_r[s] <= deg_r[s-1];
      end
      for (int s = 8; s <= NSt; s++) cs_r[s] <= cs_r[s-1];
    end
  end

  assign out_valid   = vld_r[NSt-1];
  assign out_sum     = sum10_r;
  assign out_geo.cs  = cs_r[NSt];
  assign out_geo.neg = neg_r[NSt];
  assign out_geo.k   = k_r[NSt];
  assign out_geo.deg = deg_r[NSt];
  assign out_geo.v1  = v1_r[NSt];
  assign out_geo.pt  = pt_r[NSt];

endmodule

@@ rtl/tpo_sqrt.sv @@
module tpo_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [tpo_pkg::SumW-1:0]  in_sum,
  input  tpo_pkg::geo_t             in_geo,
  output logic                      out_valid,
  output logic [tpo_pkg::RootW-1:0] out_root,
  output tpo_pkg::geo_t             out_geo
);

  // One root bit per stage, two radicand bits consumed per stage.
  localparam int NSt  = tpo_pkg::RootW;
  localparam int RadW = 2 * NSt;
  localparam int RemW = NSt + 3;

  logic [NSt-1:0]  vld_r;
  logic [RemW-1:0] rem_r [NSt];
  logic [RemW-1:0] rem_nxt [NSt];
  logic [NSt-1:0]  root_r [NSt];
  logic [NSt-1:0]  root_nxt [NSt];
  logic [RadW-1:0] rad_r [NSt];
  logic [RadW-1:0] rad_nxt [NSt];
  tpo_pkg::geo_t   geo_r [NSt];

  always_comb begin
    logic [RemW-1:0] rem_c;
    logic [NSt-1:0]  root_c;
    logic [RadW-1:0] rad_c;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] tv;
    for (int j = 0; j < NSt; j++) begin
      if (j == 0) begin
        rem_c  = '0;
        root_c = '0;
        rad_c  = RadW'(in_sum);
      end else begin
        rem_c  = rem_r[(j > 0) ? j - 1 : 0];
        root_c = root_r[(j > 0) ? j - 1 : 0];
        rad_c  = rad_r[(j > 0) ? j - 1 : 0];
      end
      trial = {rem_c[RemW-3:0], rad_c[RadW-1 -: 2]};
      tv    = RemW'({root_c, 2'b01});
      if (trial >= tv) begin
        rem_nxt[j]  = trial - tv;
        root_nxt[j] = {root_c[NSt-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = trial;
        root_nxt[j] = {root_c[NSt-2:0], 1'b0};
      end
      rad_nxt[j] = {rad_c[RadW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSt-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NSt; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        rad_r[j]  <= rad_nxt[j];
      end
      geo_r[0] <= in_geo;
      for (int j = 1; j < NSt; j++) geo_r[j] <= geo_r[j-1];
    end
  end

  assign out_valid = vld_r[NSt-1];
  assign out_root  = root_r[NSt-1];
  assign out_geo   = geo_r[NSt-1];

endmodule

@@ rtl/tpo_div.sv @@
module tpo_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [tpo_pkg::RootW-1:0]           in_root,
  input  tpo_pkg::geo_t                       in_geo,
  output logic                                out_valid,
  output logic [2:0][tpo_pkg::QuotW-1:0]      out_quot,
  output tpo_pkg::div_side_t                  out_side
);

  // A setup stage forms the rounded numerator, then one quotient bit per stage.
  localparam int QuotW = tpo_pkg::QuotW;
  localparam int NSt   = QuotW + 1;
  localparam int NumW  = tpo_pkg::MagW + tpo_pkg::FracW + 1;
  localparam int RemW  = tpo_pkg::RootW + 1;

  logic [NSt-1:0]         vld_r;
  logic [2:0][RemW-1:0]   rem_r [NSt];
  logic [2:0][RemW-1:0]   rem_nxt [NSt];
  logic [2:0][QuotW-1:0]  low_r [NSt];
  logic [2:0][QuotW-1:0]  low_nxt [NSt];
  logic [2:0][QuotW-1:0]  quot_r [NSt];
  logic [2:0][QuotW-1:0]  quot_nxt [NSt];
  tpo_pkg::div_side_t     side_r [NSt];

  always_comb begin
    logic [NumW-1:0] num;
    logic [RemW-1:0] dvs;
    logic [RemW-1:0] trial;
    for (int i = 0; i < 3; i++) begin
      num = (NumW'(in_geo.cs[i]) << tpo_pkg::FracW) + NumW'(in_root >> 1);
      rem_nxt[0][i]  = RemW'(num[NumW-1:QuotW]);
      low_nxt[0][i]  = num[QuotW-1:0];
      quot_nxt[0][i] = '0;
    end
    for (int j = 1; j < NSt; j++) begin
      dvs = RemW'(side_r[j-1].lp);
      for (int i = 0; i < 3; i++) begin
        trial = {rem_r[j-1][i][RemW-2:0], low_r[j-1][i][QuotW-1]};
        if (trial >= dvs) begin
          rem_nxt[j][i]  = trial - dvs;
          quot_nxt[j][i] = {quot_r[j-1][i][QuotW-2:0], 1'b1};
        end else begin
          rem_nxt[j][i]  = trial;
          quot_nxt[j][i] = {quot_r[j-1][i][QuotW-2:0], 1'b0};
        end
        low_nxt[j][i] = {low_r[j-1][i][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSt-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NSt; j++) begin
        rem_r[j]  <= rem_nxt[j];
        low_r[j]  <= low_nxt[j];
        quot_r[j] <= quot_nxt[j];
      end
      side_r[0].lp  <= in_root;
      side_r[0].geo <= in_geo;
      for (int j = 1; j < NSt; j++) side_r[j] <= side_r[j-1];
    end
  end

  assign out_valid = vld_r[NSt-1];
  assign out_quot  = quot_r[NSt-1];
  assign out_side  = side_r[NSt-1];

endmodule

@@ rtl/tpo_plane.sv @@
module tpo_plane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [2:0][tpo_pkg::QuotW-1:0]    in_quot,
  input  tpo_pkg::div_side_t                in_side,
  input  logic [tpo_pkg::CoordW-1:0]        tol,
  output logic                              out_valid,
  output tpo_pkg::result_t                  out_res
);

  localparam int NSt     = 5;
  localparam int NormW   = tpo_pkg::NormW;
  localparam int QuotW   = tpo_pkg::QuotW;
  localparam int FracW   = tpo_pkg::FracW;
  localparam int DotW    = tpo_pkg::DotW;
  localparam int PrdW    = tpo_pkg::NormW + tpo_pkg::CoordW;
  localparam int OfsW    = tpo_pkg::OfsW;
  localparam int RawW    = DotW - FracW;
  localparam int LenW    = tpo_pkg::LenW;
  localparam int ShW     = tpo_pkg::ShiftW + 1;
  localparam logic [QuotW-1:0]       NormOne   = QuotW'(1) << FracW;
  localparam logic signed [DotW-1:0] RoundHalf = DotW'(1) << (FracW - 1);
  localparam logic signed [RawW:0]   OfsMax    = (RawW + 1)'(2 ** (OfsW - 1) - 1);
  localparam logic signed [RawW:0]   OfsMin    = (RawW + 1)'(-(2 ** (OfsW - 1)));

  logic [NSt-1:0]          vld_r;
  logic signed [NormW-1:0] n_r [1:4][3];
  logic [LenW-1:0]         len_r [1:4];
  logic                    deg_r [1:4];
  tpo_pkg::vec_t           v1_r;
  tpo_pkg::vec_t           pt_r;
  logic signed [PrdW-1:0]  pd2_r [3];
  logic signed [PrdW-1:0]  px2_r [3];
  logic signed [DotW-1:0]  d1_3_r;
  logic signed [DotW-1:0]  dx3_r;
  logic signed [DotW-1:0]  diff4_r;
  logic signed [RawW-1:0]  ofs4_r;
  tpo_pkg::result_t        res_r;

  logic signed [NormW-1:0] n_c [3];
  logic [QuotW-1:0]        qc;
  logic [ShW-1:0]          len_sh;
  logic signed [DotW-1:0]  thr;
  logic                    flip_c;
  logic signed [RawW:0]    ofs_pos;
  logic signed [RawW:0]    ofs_neg;

  function automatic logic signed [OfsW-1:0] sat_ofs(input logic signed [RawW:0] v);
    if (v > OfsMax) return OfsMax[OfsW-1:0];
    if (v < OfsMin) return OfsMin[OfsW-1:0];
    return v[OfsW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc     = (in_quot[i] > NormOne) ? NormOne : in_quot[i];
      n_c[i] = in_side.geo.neg[i] ? -$signed(NormW'(qc)) : $signed(NormW'(qc));
      if (in_side.geo.deg) n_c[i] = '0;
    end
    len_sh  = ShW'(in_side.geo.k) + ShW'(tpo_pkg::LenShift);
    thr     = DotW'($signed(tol)) <<< FracW;
    // A point outside the half space by more than the tolerance flips the plane.
    flip_c  = !deg_r[4] && (diff4_r > thr);
    ofs_pos = (RawW + 1)'(ofs4_r);
    ofs_neg = -ofs_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSt-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[1]   <= n_c;
      len_r[1] <= LenW'(in_side.lp >> len_sh);
      deg_r[1] <= in_side.geo.deg;
      v1_r     <= in_side.geo.v1;
      pt_r     <= in_side.geo.pt;
      for (int s = 2; s <= 4; s++) begin
        n_r[s]   <= n_r[s-1];
        len_r[s] <= len_r[s-1];
        deg_r[s] <= deg_r[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        pd2_r[i] <= n_r[1][i] * $signed(v1_r[i]);
        px2_r[i] <= n_r[1][i] * $signed(pt_r[i]);
      end
      d1_3_r  <= DotW'(pd2_r[0]) + DotW'(pd2_r[1]) + DotW'(pd2_r[2]);
      dx3_r   <= DotW'(px2_r[0]) + DotW'(px2_r[1]) + DotW'(px2_r[2]);
      diff4_r <= dx3_r - d1_3_r;
      ofs4_r  <= RawW'((d1_3_r + RoundHalf) >>> FracW);
      res_r.nx     <= flip_c ? -n_r[4][0] : n_r[4][0];
      res_r.ny     <= flip_c ? -n_r[4][1] : n_r[4][1];
      res_r.nz     <= flip_c ? -n_r[4][2] : n_r[4][2];
      res_r.offset <= flip_c ? sat_ofs(ofs_neg) : sat_ofs(ofs_pos);
      res_r.len    <= len_r[4];
      res_r.deg    <= deg_r[4];
      res_r.flip   <= flip_c;
    end
  end

  assign out_valid = vld_r[NSt-1];
  assign out_res   = res_r;

endmodule

@@ rtl/tpo_checker.sv @@
module tpo_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         cfg_we,
  input logic [23:0]  cfg_wdata,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [287:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [1:0]   out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word present right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[157:0] == '0) && !out_tuser[1])
    else $error("degenerate word carries a nonzero plane or a flip");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= 32'sd1073741824)
                && ($signed(out_tdata[31:0]) >= -32'sd1073741824))
    else $error("normal x outside the unit range");

endmodule

bind triangle_plane_orient_top tpo_checker u_tpo_checker (.*);

@@ verif/triangle_plane_orient_top_tb.sv @@
module triangle_plane_orient_top_tb;

  typedef struct {
    logic [287:0]     word;
    bit               typed;
    tpo_pkg::result_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [23:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic [1:0]   out_tuser;

  tpo_pkg::result_t pending_planes[$];
  stim_row_t        stim_rows[$];
  longint           tolerance_now = 0;
  int               error_count = 0;
  int               burst_left = 0;
  bit               hold_request = 1'b0;

  triangle_plane_orient_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] sum_of_squares(input logic [63:0] a, b, c);
    logic [127:0] wa, wb, wc;
    wa = a;
    wb = b;
    wc = c;
    return wa * wa + wb * wb + wc * wc;
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] s);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int b = 52; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t[63:0];
    end
    return r;
  endfunction

  // Oriented plane of one triangle word, at the given tolerance.
  function automatic tpo_pkg::result_t orient_plane(input logic [287:0] d, input longint tol);
    longint           v[12];
    longint           p[3], q[3], c[3], n[3];
    logic [63:0]      m[3], cs[3], top, lp, len;
    logic [127:0]     s, num;
    longint           d1, dx, ofs;
    int               k;
    bit               flip;
    tpo_pkg::result_t r;
    for (int i = 0; i < 12; i++) v[i] = $signed(d[24*i +: 24]);
    for (int i = 0; i < 3; i++) begin
      p[i] = v[6+i] - v[i];
      q[i] = v[3+i] - v[i];
      n[i] = 0;
    end
    c[0] = p[1] * q[2] - p[2] * q[1];
    c[1] = p[2] * q[0] - p[0] * q[2];
    c[2] = p[0] * q[1] - p[1] * q[0];
    for (int i = 0; i < 3; i++) m[i] = c[i] < 0 ? -c[i] : c[i];
    s = sum_of_squares(m[0], m[1], m[2]);
    len = floor_root(s) >> 16;
    if (len > 64'hF_FFFF_FFFF) len = 64'hF_FFFF_FFFF;
    ofs = 0;
    flip = 1'b0;
    if (s != 0) begin
      top = m[0];
      if (m[1] > top) top = m[1];
      if (m[2] > top) top = m[2];
      // Normalize so the largest component sits at or just below 2^49.
      k = 0;
      while (k < 60 && (top << (k + 1)) <= (64'd1 << 49)) k++;
      for (int i = 0; i < 3; i++) cs[i] = m[i] << k;
      lp = floor_root(sum_of_squares(cs[0], cs[1], cs[2]));
      for (int i = 0; i < 3; i++) begin
        num = (({64'd0, cs[i]} << 30) + (lp >> 1)) / lp;
        if (num > (128'd1 << 30)) num = 128'd1 << 30;
        n[i] = c[i] < 0 ? -longint'(num[63:0]) : longint'(num[63:0]);
      end
      d1 = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
      dx = n[0] * v[9] + n[1] * v[10] + n[2] * v[11];
      ofs = (d1 + (longint'(1) <<< 29)) >>> 30;
      flip = (dx - d1) > tol * (longint'(1) <<< 30);
      if (flip) begin
        for (int i = 0; i < 3; i++) n[i] = -n[i];
        ofs = -ofs;
      end
      if (ofs > 33554431) ofs = 33554431;
      if (ofs < -33554432) ofs = -33554432;
    end
    r.nx = n[0][31:0];
    r.ny = n[1][31:0];
    r.nz = n[2][31:0];
    r.offset = ofs[25:0];
    r.len = (s == 0) ? '0 : len[35:0];
    r.deg = (s == 0);
    r.flip = flip;
    return r;
  endfunction

  function automatic tpo_pkg::vec_t mkv(input longint x, y, z);
    tpo_pkg::vec_t r;
    r[0] = x[23:0];
    r[1] = y[23:0];
    r[2] = z[23:0];
    return r;
  endfunction

  function automatic logic [287:0] mkword(input tpo_pkg::vec_t v1, v2, v3, pt);
    return {pt, v3, v2, v1};
  endfunction

  function automatic tpo_pkg::result_t mkres(input longint nx, ny, nz, ofs, len,
                                             bit deg, flip);
    tpo_pkg::result_t r;
    r.nx = nx[31:0];
    r.ny = ny[31:0];
    r.nz = nz[31:0];
    r.offset = ofs[25:0];
    r.len = len[35:0];
    r.deg = deg;
    r.flip = flip;
    return r;
  endfunction

  task automatic add_row(input logic [287:0] w, input bit typed, input tpo_pkg::result_t want);
    stim_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    stim_rows = {stim_rows, row};
  endtask

  // Offers one word in bursts with random gaps, then queues its expected plane.
  task automatic send_word(input logic [287:0] w, input bit typed,
                           input tpo_pkg::result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pending_planes = {pending_planes, (typed ? want : orient_plane(w, tolerance_now))};
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_planes.size() != 0) @(posedge clk);
  endtask

  task automatic set_tolerance(input longint tol);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= tol[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance_now = tol;
  endtask

  function automatic logic [287:0] random_word();
    tpo_pkg::vec_t v1, v2, v3, pt;
    longint        bx, by, bz;
    int            sp;
    int            kind;
    kind = $urandom_range(0, 9);
    bx = $signed(24'($urandom_range(0, 8388607) - 4194304));
    by = $signed(24'($urandom_range(0, 8388607) - 4194304));
    bz = $signed(24'($urandom_range(0, 8388607) - 4194304));
    sp = 1 << $urandom_range(0, 20);
    v1 = mkv(bx, by, bz);
    v2 = mkv(bx + $urandom_range(0, 2*sp) - sp, by + $urandom_range(0, 2*sp) - sp,
             bz + $urandom_range(0, 2*sp) - sp);
    v3 = mkv(bx + $urandom_range(0, 2*sp) - sp, by + $urandom_range(0, 2*sp) - sp,
             bz + $urandom_range(0, 2*sp) - sp);
    pt = mkv(bx + $urandom_range(0, 2*sp) - sp, by + $urandom_range(0, 2*sp) - sp,
             bz + $urandom_range(0, 2*sp) - sp);
    case (kind)
      0, 1: begin
        // Arbitrary bit patterns over the whole coordinate range.
        for (int i = 0; i < 3; i++) begin
          v1[i] = 24'($urandom);
          v2[i] = 24'($urandom);
          v3[i] = 24'($urandom);
          pt[i] = 24'($urandom);
        end
      end
      2: begin
        // Collinear vertices give a zero cross product.
        v3 = mkv(2 * $signed(v2[0]) - bx, 2 * $signed(v2[1]) - by, 2 * $signed(v2[2]) - bz);
      end
      3: pt = v1;
      default: ;
    endcase
    return mkword(v1, v2, v3, pt);
  endfunction

  always @(posedge clk) begin
    tpo_pkg::result_t exp_r, got;
    if (out_tvalid && out_tready) begin
      got.nx = out_tdata[31:0];
      got.ny = out_tdata[63:32];
      got.nz = out_tdata[95:64];
      got.offset = out_tdata[121:96];
      got.len = out_tdata[157:122];
      got.deg = out_tuser[0];
      got.flip = out_tuser[1];
      if (pending_planes.size() == 0) begin
        $display("%0t: unexpected word %h %b", $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_r = pending_planes.pop_front();
        if (got.nx !== exp_r.nx || got.ny !== exp_r.ny || got.nz !== exp_r.nz) begin
          $display("%0t: normal expected %0d %0d %0d actual %0d %0d %0d", $time,
                   exp_r.nx, exp_r.ny, exp_r.nz, got.nx, got.ny, got.nz);
          error_count++;
        end
        if (got.offset !== exp_r.offset) begin
          $display("%0t: offset expected %0d actual %0d", $time, exp_r.offset, got.offset);
          error_count++;
        end
        if (got.len !== exp_r.len) begin
          $display("%0t: length expected %0d actual %0d", $time, exp_r.len, got.len);
          error_count++;
        end
        if (got.deg !== exp_r.deg || got.flip !== exp_r.flip) begin
          $display("%0t: flags expected deg %b flip %b actual deg %b flip %b", $time,
                   exp_r.deg, exp_r.flip, got.deg, got.flip);
          error_count++;
        end
      end
    end
  end

  // Receiver: switches between random stall patterns, or holds off on request.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("** triangle_plane_orient_top: FAILED **");
    $finish;
  end

  initial begin
    longint           mx, mn;
    longint           phase_tol[5];
    tpo_pkg::result_t none;
    mx = 8388607;
    mn = -8388608;
    none = mkres(0, 0, 0, 0, 0, 1'b1, 1'b0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mkword(mkv(0, 0, 0), mkv(0, 0, 0), mkv(0, 0, 0), mkv(0, 0, 0)), 1'b1, none);
    add_row(mkword(mkv(0, 0, 0), mkv(65536, 0, 0), mkv(0, 65536, 0), mkv(0, 0, 0)), 1'b1,
            mkres(0, 0, -(1 << 30), 0, 65536, 1'b0, 1'b0));
    add_row(mkword(mkv(0, 0, 0), mkv(65536, 0, 0), mkv(0, 65536, 0), mkv(0, 0, 65536)), 1'b1,
            mkres(0, 0, -(1 << 30), 0, 65536, 1'b0, 1'b0));
    // Reference point on the wrong side flips the plane.
    add_row(mkword(mkv(0, 0, 0), mkv(65536, 0, 0), mkv(0, 65536, 0), mkv(0, 0, -65536)), 1'b1,
            mkres(0, 0, 1 << 30, 0, 65536, 1'b0, 1'b1));
    // Smallest nonzero cross product: length rounds to zero but not degenerate.
    add_row(mkword(mkv(0, 0, 0), mkv(1, 0, 0), mkv(0, 1, 0), mkv(0, 0, 0)), 1'b1,
            mkres(0, 0, -(1 << 30), 0, 0, 1'b0, 1'b0));
    add_row(mkword(mkv(0, 0, 0), mkv(1, 1, 1), mkv(2, 2, 2), mkv(5, 5, 5)), 1'b1, none);
    add_row(mkword(mkv(7, 8, 9), mkv(7, 8, 9), mkv(1, 2, 3), mkv(0, 0, 0)), 1'b1, none);
    add_row(mkword(mkv(mx, mx, mx), mkv(mx, mx, mx), mkv(mx, mx, mx), mkv(mx, mx, mx)), 1'b1, none);
    add_row(mkword(mkv(mn, mn, mn), mkv(mn, mn, mn), mkv(mn, mn, mn), mkv(mn, mn, mn)), 1'b1, none);
    add_row(mkword(mkv(mn, mn, mn), mkv(mx, mn, mn), mkv(mn, mx, mn), mkv(mx, mx, mx)), 1'b0, none);
    add_row(mkword(mkv(mx, mx, mx), mkv(mn, mx, mx), mkv(mx, mn, mx), mkv(mn, mn, mn)), 1'b0, none);
    add_row(mkword(mkv(mn, mx, mn), mkv(mx, mn, mx), mkv(mx, mx, mn), mkv(0, 0, 0)), 1'b0, none);
    add_row(mkword(mkv(mx, mn, mx), mkv(mn, mx, mn), mkv(mn, mn, mx), mkv(mx, mn, 0)), 1'b0, none);
    add_row(mkword(mkv(mx, mx, mx), mkv(mx, mx, mn), mkv(mn, mx, mx), mkv(mn, mn, mn)), 1'b0, none);
    add_row(mkword(mkv(mx, mx, 0), mkv(mx, 0, mx), mkv(0, mx, mx), mkv(0, 0, 0)), 1'b0, none);
    add_row(mkword(mkv(100, -200, 300), mkv(5000, 70, -9), mkv(-40, 600, 1234),
                   mkv(100, -200, 300)), 1'b0, none);
    add_row(mkword(mkv(mn, 0, 0), mkv(mx, 1, 0), mkv(mx, 0, 1), mkv(mx, mx, mx)), 1'b0, none);
    foreach (stim_rows[i]) send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);

    phase_tol[0] = mx;
    phase_tol[1] = mn;
    phase_tol[2] = $signed(24'($urandom));
    phase_tol[3] = longint'($urandom_range(0, 2048)) - 1024;
    phase_tol[4] = 0;
    for (int ph = 0; ph < 5; ph++) begin
      set_tolerance(phase_tol[ph]);
      for (int i = 0; i < 220; i++) begin
        if (ph == 2 && i == 60) hold_request = 1'b1;
        send_word(random_word(), 1'b0, none);
      end
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (error_count == 0) begin
      $display("** triangle_plane_orient_top: PASSED **");
    end else begin
      $display("** triangle_plane_orient_top: FAILED **");
    end
    $finish;
  end

endmodule
